>>> src/ows_pkg.sv
// Shared types, codes and sizes of the one-wire slot sequencer.
package ows_pkg;

   // Byte stores for write data and read data
   localparam int MAX_BYTES = 16;
   localparam int MAX_BITS  = MAX_BYTES * 8;
   localparam int BYTE_W    = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
   localparam int LIMIT_W   = $clog2(MAX_BITS + 1);

   // Tick sums: 16-bit slot plus two 10-bit delays
   localparam int TICK_W = 17;

   // Power-on timing
   localparam logic [15:0] RESET_LOW_DEFAULT     = 16'd12860;
   localparam logic [15:0] PRESENCE_WAIT_DEFAULT = 16'd25720;
   localparam logic [15:0] SLOT_DEFAULT          = 16'd1672;
   localparam logic [9:0]  SHORT_PULSE_DEFAULT   = 10'd50;
   localparam logic [9:0]  SAMPLE_DELAY_DEFAULT  = 10'd283;

   typedef enum logic [2:0] {
      CSR_RESET_LOW     = 3'd0,
      CSR_PRESENCE_WAIT = 3'd1,
      CSR_SLOT          = 3'd2,
      CSR_SHORT_PULSE   = 3'd3,
      CSR_SAMPLE_DELAY  = 3'd4
   } csr_idx_type;

   typedef enum logic [1:0] {
      ACT_START    = 2'd0,
      ACT_LOAD     = 2'd1,
      ACT_EVENT    = 2'd2,
      ACT_READBACK = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_RESET = 2'd1,
      PH_WRITE = 2'd2,
      PH_READ  = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ST_RST_BEGIN  = 3'd0,
      ST_RST_END    = 3'd1,
      ST_PRES_END   = 3'd2,
      ST_WR_BEGIN   = 3'd3,
      ST_WR_END     = 3'd4,
      ST_RD_BEGIN   = 3'd5,
      ST_RD_END     = 3'd6
   } step_type;

   typedef enum logic [1:0] {
      LINE_NONE    = 2'd0,
      LINE_LOW     = 2'd1,
      LINE_RELEASE = 2'd2,
      LINE_PULSE   = 2'd3
   } line_cmd_type;

   typedef enum logic [1:0] {
      EDGE_KEEP = 2'd0,
      EDGE_FALL = 2'd1,
      EDGE_OFF  = 2'd2
   } edge_type;

   typedef struct packed {
      logic [15:0]       reset_low;
      logic [15:0]       presence_wait;
      logic [15:0]       slot;
      logic [TICK_W-1:0] rd_ticks;
      logic [TICK_W-1:0] wr1_ticks;
   } cfg_type;

   typedef struct packed {
      action_type  action;
      logic [1:0]  operation;
      logic [7:0]  bit_count;
      logic [3:0]  byte_index;
      logic [7:0]  byte_value;
      logic [31:0] counter_now;
      logic        line_level;
   } item_type;

   typedef struct packed {
      line_cmd_type line_command;
      logic         match_valid;
      logic [31:0]  match_value;
      logic         timer_stop;
      edge_type     edge_control;
      logic         read_valid;
      logic         read_bit;
      logic         op_done;
      logic         signal_software;
      logic [31:0]  event_count;
      logic [7:0]   read_byte;
   } result_type;

   typedef struct packed {
      logic       load_en;
      logic [3:0] load_idx;
      logic [7:0] load_val;
      logic       bit_wr_en;
      logic [7:0] bit_sel;
      logic       bit_val;
      logic [3:0] rb_idx;
   } store_req_type;

endpackage

>>> src/ows_store.sv
// Write-data and read-data byte stores of the one-wire slot sequencer.
module ows_store (
   input  logic                  clock,
   input  ows_pkg::store_req_type store_req,
   output logic                  wbit,
   output logic [7:0]            store_byte
);
   import ows_pkg::*;

   logic [7:0] write_store_ff [MAX_BYTES];
   logic [7:0] read_store_ff  [MAX_BYTES];

   logic              load_ok;
   logic              bit_ok;
   logic              rb_ok;
   logic [BYTE_W-1:0] load_sel;
   logic [BYTE_W-1:0] bit_byte;
   logic [BYTE_W-1:0] rb_sel;

   // Range checks against the store depth
   assign load_ok  = {2'b00, store_req.load_idx} < 6'(MAX_BYTES);
   assign rb_ok    = {2'b00, store_req.rb_idx} < 6'(MAX_BYTES);
   assign bit_ok   = {1'b0, store_req.bit_sel[7:3]} < 6'(MAX_BYTES);
   assign load_sel = BYTE_W'(store_req.load_idx);
   assign rb_sel   = BYTE_W'(store_req.rb_idx);
   assign bit_byte = BYTE_W'(store_req.bit_sel[7:3]);

   // Load write bytes, store sampled read bits LSB first
   always_ff @(posedge clock) begin
      if (store_req.load_en && load_ok) begin
         write_store_ff[load_sel] <= store_req.load_val;
      end
      if (store_req.bit_wr_en && bit_ok) begin
         read_store_ff[bit_byte][store_req.bit_sel[2:0]] <= store_req.bit_val;
      end
   end

   // Out-of-range positions read as zero
   assign wbit       = bit_ok ? write_store_ff[bit_byte][store_req.bit_sel[2:0]] : 1'b0;
   assign store_byte = rb_ok ? read_store_ff[rb_sel] : 8'd0;

endmodule

>>> src/ows_seq.sv
// Slot state machine, flags and event counter of the one-wire slot sequencer.
module ows_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  ows_pkg::item_type      item,
   input  ows_pkg::cfg_type       cfg,
   input  logic                   wbit,
   input  logic [7:0]             store_byte,
   output ows_pkg::store_req_type store_req,
   output ows_pkg::result_type    result
);
   import ows_pkg::*;

   phase_type          phase_ff, phase_in;
   step_type           step_ff, step_in;
   logic [7:0]         bit_index_ff, bit_index_in;
   logic [LIMIT_W-1:0] bit_limit_ff, bit_limit_in;
   logic               done_ff, done_in;
   logic               signal_ff, signal_in;
   logic [31:0]        events_ff, events_in;

   logic is_start, is_event;
   logic rst_begin, rst_end, pres_end, slot_begin, slot_end;
   logic overrun, last_bit;

   line_cmd_type      cmd;
   logic              mv;
   logic [TICK_W-1:0] ticks;
   logic              stop;
   edge_type          edge_ctl;
   logic              rv;
   logic              set_done;
   logic              set_signal;

   // Decode the current slot situation
   assign is_start   = item.action == ACT_START;
   assign is_event   = item.action == ACT_EVENT;
   assign rst_begin  = phase_ff == PH_RESET && step_ff == ST_RST_BEGIN;
   assign rst_end    = phase_ff == PH_RESET && step_ff == ST_RST_END;
   assign pres_end   = phase_ff == PH_RESET && step_ff == ST_PRES_END;
   assign slot_begin = (phase_ff == PH_WRITE && step_ff == ST_WR_BEGIN) ||
                       (phase_ff == PH_READ && step_ff == ST_RD_BEGIN);
   assign slot_end   = (phase_ff == PH_WRITE && step_ff == ST_WR_END) ||
                       (phase_ff == PH_READ && step_ff == ST_RD_END);
   assign overrun    = {1'b0, bit_index_ff} >= 9'(bit_limit_ff);
   assign last_bit   = ({1'b0, bit_index_ff} + 9'd1) >= 9'(bit_limit_ff);

   // Outputs of one match event
   always_comb begin
      cmd        = LINE_NONE;
      mv         = 1'b0;
      ticks      = '0;
      stop       = 1'b0;
      edge_ctl   = EDGE_KEEP;
      rv         = 1'b0;
      set_done   = 1'b0;
      set_signal = 1'b0;
      if (is_event) begin
         if (phase_ff == PH_IDLE) begin
            stop = 1'b1;
         end else if (rst_begin) begin
            cmd   = LINE_LOW;
            mv    = 1'b1;
            ticks = TICK_W'(cfg.reset_low);
         end else if (rst_end) begin
            cmd      = LINE_RELEASE;
            edge_ctl = EDGE_FALL;
            mv       = 1'b1;
            ticks    = TICK_W'(cfg.presence_wait);
         end else if (pres_end) begin
            stop       = 1'b1;
            edge_ctl   = EDGE_OFF;
            set_done   = 1'b1;
            set_signal = 1'b1;
         end else if (slot_begin) begin
            if (overrun) begin
               stop       = 1'b1;
               cmd        = LINE_RELEASE;
               set_signal = 1'b1;
            end else if (phase_ff == PH_READ) begin
               cmd   = LINE_PULSE;
               rv    = 1'b1;
               mv    = 1'b1;
               ticks = cfg.rd_ticks;
            end else if (wbit) begin
               cmd   = LINE_PULSE;
               mv    = 1'b1;
               ticks = cfg.wr1_ticks;
            end else begin
               cmd   = LINE_LOW;
               mv    = 1'b1;
               ticks = TICK_W'(cfg.slot);
            end
         end else if (slot_end) begin
            if (last_bit) begin
               stop       = 1'b1;
               set_done   = 1'b1;
               set_signal = 1'b1;
            end else begin
               mv    = 1'b1;
               ticks = TICK_W'(cfg.slot);
            end
            if (phase_ff == PH_WRITE && !wbit) begin
               cmd = LINE_RELEASE;
            end
         end else begin
            stop       = 1'b1;
            set_signal = 1'b1;
         end
      end
   end

   // Next state of the sequencer
   always_comb begin
      phase_in     = phase_ff;
      step_in      = step_ff;
      bit_index_in = bit_index_ff;
      bit_limit_in = bit_limit_ff;
      done_in      = done_ff | set_done;
      signal_in    = signal_ff | set_signal;
      events_in    = events_ff;
      if (is_start) begin
         phase_in = phase_type'(item.operation);
         case (phase_type'(item.operation))
            PH_WRITE: step_in = ST_WR_BEGIN;
            PH_READ:  step_in = ST_RD_BEGIN;
            default:  step_in = ST_RST_BEGIN;
         endcase
         bit_index_in = '0;
         bit_limit_in = ({1'b0, item.bit_count} < 9'(MAX_BITS)) ?
                        LIMIT_W'(item.bit_count) : LIMIT_W'(MAX_BITS);
         done_in      = 1'b0;
         signal_in    = 1'b0;
      end else if (is_event) begin
         events_in = events_ff + 32'd1;
         if (rst_begin) begin
            step_in = ST_RST_END;
         end else if (rst_end) begin
            step_in = ST_PRES_END;
         end else if (pres_end) begin
            step_in = ST_RST_BEGIN;
         end else if (slot_begin && !overrun) begin
            step_in = (phase_ff == PH_READ) ? ST_RD_END : ST_WR_END;
         end else if (slot_end) begin
            bit_index_in = bit_index_ff + 8'd1;
            step_in      = (phase_ff == PH_READ) ? ST_RD_BEGIN : ST_WR_BEGIN;
         end
      end
   end

   // Advance state on each word taken in
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         step_ff      <= ST_RST_BEGIN;
         bit_index_ff <= '0;
         bit_limit_ff <= '0;
         done_ff      <= 1'b0;
         signal_ff    <= 1'b0;
         events_ff    <= '0;
      end else if (fire) begin
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         bit_index_ff <= bit_index_in;
         bit_limit_ff <= bit_limit_in;
         done_ff      <= done_in;
         signal_ff    <= signal_in;
         events_ff    <= events_in;
      end
   end

   // Store accesses
   always_comb begin
      store_req.load_en   = fire && item.action == ACT_LOAD;
      store_req.load_idx  = item.byte_index;
      store_req.load_val  = item.byte_value;
      store_req.bit_wr_en = fire && rv;
      store_req.bit_sel   = bit_index_ff;
      store_req.bit_val   = item.line_level;
      store_req.rb_idx    = item.byte_index;
   end

   // Assemble the result word
   always_comb begin
      result.line_command    = cmd;
      result.match_valid     = mv;
      result.match_value     = mv ? (item.counter_now + 32'(ticks)) : 32'd0;
      result.timer_stop      = stop;
      result.edge_control    = edge_ctl;
      result.read_valid      = rv;
      result.read_bit        = rv & item.line_level;
      result.op_done         = done_in;
      result.signal_software = signal_in;
      result.event_count     = events_in;
      result.read_byte       = (item.action == ACT_READBACK) ? store_byte : 8'd0;
   end

endmodule

>>> src/one_wire_slot_sequencer_top.sv
// Top level of the one-wire slot sequencer: registers, handshake and checks.
//
// Usage: each request word carries an action. A start word picks the
// operation (idle, reset and presence, write bits, read bits) and the bit
// count; load words fill the write byte store beforehand (bit 0 of byte 0
// goes out first); a timer match word steps the slot machine; a read-back
// word returns one stored read byte. Every request word yields exactly one
// response word with the line command, next compare value, timer stop,
// edge-detect control, sampled read bit, sticky done and software flags,
// the event count and the read-back byte.
// A word taken is held in the input register and its response is presented
// from the response register. Throughput is one word per cycle while the
// receiver takes responses; the slot step is a single add of the compare
// value behind the input register.
// A stalled receiver holds the response register; one more request word
// waits in the input register, then req_ready drops until rsp_ready.
// Reset (synchronous, active high) returns the timing registers to their
// defaults and the sequencer to idle; the byte stores hold no reset value.
// The csr port writes timing registers; write only while the block is idle.
module one_wire_slot_sequencer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_bit_count,
   input  logic [3:0]  req_byte_index,
   input  logic [7:0]  req_byte_value,
   input  logic [31:0] req_counter_now,
   input  logic        req_line_level,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_line_command,
   output logic        rsp_match_valid,
   output logic [31:0] rsp_match_value,
   output logic        rsp_timer_stop,
   output logic [1:0]  rsp_edge_control,
   output logic        rsp_read_valid,
   output logic        rsp_read_bit,
   output logic        rsp_op_done,
   output logic        rsp_signal_software,
   output logic [31:0] rsp_event_count,
   output logic [7:0]  rsp_read_byte
);
   import ows_pkg::*;

   logic [15:0]       reset_low_ff, presence_wait_ff, slot_ff;
   logic [9:0]        short_pulse_ff, sample_delay_ff;
   logic [TICK_W-1:0] rd_ticks_ff, wr1_ticks_ff;
   cfg_type           cfg;

   item_type      item_ff;
   logic          in_valid_ff, in_valid_in;
   result_type    result;
   result_type    out_ff;
   logic          out_valid_ff, out_valid_in;
   logic          fire;
   logic          take;
   store_req_type store_req;
   logic          wbit;
   logic [7:0]    store_byte;

   // Timing registers
   always_ff @(posedge clock) begin
      if (reset) begin
         reset_low_ff     <= RESET_LOW_DEFAULT;
         presence_wait_ff <= PRESENCE_WAIT_DEFAULT;
         slot_ff          <= SLOT_DEFAULT;
         short_pulse_ff   <= SHORT_PULSE_DEFAULT;
         sample_delay_ff  <= SAMPLE_DELAY_DEFAULT;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RESET_LOW:     reset_low_ff     <= csr_wdata;
            CSR_PRESENCE_WAIT: presence_wait_ff <= csr_wdata;
            CSR_SLOT:          slot_ff          <= csr_wdata;
            CSR_SHORT_PULSE:   short_pulse_ff   <= csr_wdata[9:0];
            CSR_SAMPLE_DELAY:  sample_delay_ff  <= csr_wdata[9:0];
            default:           ;
         endcase
      end
   end

   // Precompute the slot lengths of read and write-one slots
   always_ff @(posedge clock) begin
      rd_ticks_ff  <= TICK_W'(slot_ff) + TICK_W'(short_pulse_ff) + TICK_W'(sample_delay_ff);
      wr1_ticks_ff <= TICK_W'(slot_ff) + TICK_W'(short_pulse_ff);
   end

   assign cfg.reset_low     = reset_low_ff;
   assign cfg.presence_wait = presence_wait_ff;
   assign cfg.slot          = slot_ff;
   assign cfg.rd_ticks      = rd_ticks_ff;
   assign cfg.wr1_ticks     = wr1_ticks_ff;

   // Handshake: move the held word on when the response slot frees up
   assign fire         = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || fire;
   assign take         = req_valid && req_ready;
   assign in_valid_in  = take || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.action      <= action_type'(req_action);
         item_ff.operation   <= req_operation;
         item_ff.bit_count   <= req_bit_count;
         item_ff.byte_index  <= req_byte_index;
         item_ff.byte_value  <= req_byte_value;
         item_ff.counter_now <= req_counter_now;
         item_ff.line_level  <= req_line_level;
      end
   end

   ows_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .item       (item_ff),
      .cfg        (cfg),
      .wbit       (wbit),
      .store_byte (store_byte),
      .store_req  (store_req),
      .result     (result)
   );

   ows_store u_store (
      .clock      (clock),
      .store_req  (store_req),
      .wbit       (wbit),
      .store_byte (store_byte)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (fire) begin
         out_ff <= result;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_line_command    = out_ff.line_command;
   assign rsp_match_valid     = out_ff.match_valid;
   assign rsp_match_value     = out_ff.match_value;
   assign rsp_timer_stop      = out_ff.timer_stop;
   assign rsp_edge_control    = out_ff.edge_control;
   assign rsp_read_valid      = out_ff.read_valid;
   assign rsp_read_bit        = out_ff.read_bit;
   assign rsp_op_done         = out_ff.op_done;
   assign rsp_signal_software = out_ff.signal_software;
   assign rsp_event_count     = out_ff.event_count;
   assign rsp_read_byte       = out_ff.read_byte;

   // Backpressure only comes from a full response register
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request side stalled without a stalled response");

   // A sampled read bit always comes with a short pulse and a new compare
   a_read_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_read_valid) |-> (rsp_line_command == LINE_PULSE && rsp_match_valid))
      else $error("read bit outside a read slot opening");

   // Unused compare value reads as zero
   a_match_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_match_valid) |-> (rsp_match_value == 32'd0))
      else $error("compare value given without match valid");

   // Done always raises the software signal too
   a_done_signal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_op_done) |-> rsp_signal_software)
      else $error("done without software signal");

endmodule
